// File: design/pars_pkg.sv
// Shared constants, types and state codes for the point-add range-sum tree.
`default_nettype none
package pars_pkg;

  localparam int unsigned LEAF_COUNT = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned NODE_SLOTS = 2 * LEAF_COUNT;
  localparam int unsigned NODE_W     = $clog2(NODE_SLOTS);
  // One extra bit so the exclusive right bound can reach NODE_SLOTS.
  localparam int unsigned CNT_W      = NODE_W + 1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_UPD,
    ST_Q_LEFT,
    ST_Q_RIGHT
  } state_t;

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [VAL_W-1:0] add_value;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] sum;
  } res_t;

endpackage
`default_nettype wire

// File: design/pars_ram.sv
// Node-sum memory: one write port, one read port with registered read data.
`default_nettype none
module pars_ram (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [pars_pkg::NODE_W-1:0]     waddr,
  input  wire logic [pars_pkg::DATA_WIDTH-1:0] wdata,
  input  wire logic [pars_pkg::NODE_W-1:0]     raddr,
  output logic      [pars_pkg::DATA_WIDTH-1:0] rdata
);

  logic [pars_pkg::DATA_WIDTH-1:0] mem [pars_pkg::NODE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/pars_walk.sv
// Tree walker: clearing pass, leaf-to-root add and bottom-up range sum.
`default_nettype none
module pars_walk (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire pars_pkg::cmd_t       cmd,
  output logic                      busy,
  output pars_pkg::res_t            res
);

  pars_pkg::state_t state, state_next;

  logic [pars_pkg::NODE_W-1:0]     k, k_next;
  logic [pars_pkg::NODE_W-1:0]     clr_cnt, clr_cnt_next;
  logic [pars_pkg::CNT_W-1:0]      l, l_next, r, r_next;
  logic [pars_pkg::DATA_WIDTH-1:0] acc, acc_next, amt, amt_next;
  logic                            lflag, lflag_next, rflag, rflag_next;

  logic                            we;
  logic [pars_pkg::NODE_W-1:0]     waddr, raddr;
  logic [pars_pkg::DATA_WIDTH-1:0] wdata, rdata;

  logic [31:0]                     a32, b32, lo32, hi32;
  logic [pars_pkg::CNT_W-1:0]      r_dec;
  logic [pars_pkg::DATA_WIDTH-1:0] acc_r;

  pars_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pars_pkg::ST_CLEAR;
      clr_cnt <= '0;
      lflag   <= 1'b0;
      rflag   <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      lflag   <= lflag_next;
      rflag   <= rflag_next;
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    l   <= l_next;
    r   <= r_next;
    acc <= acc_next;
    amt <= amt_next;
  end

  always_comb begin
    // Query bounds saturate to the last leaf, then order themselves.
    a32   = 32'(cmd.first_index);
    b32   = 32'(cmd.second_index);
    if (a32 >= pars_pkg::LEAF_COUNT) a32 = pars_pkg::LEAF_COUNT - 1;
    if (b32 >= pars_pkg::LEAF_COUNT) b32 = pars_pkg::LEAF_COUNT - 1;
    lo32  = (a32 > b32) ? b32 : a32;
    hi32  = (a32 > b32) ? a32 : b32;
    r_dec = r - pars_pkg::CNT_W'(1);
    acc_r = acc + (rflag ? rdata : '0);

    state_next   = state;
    clr_cnt_next = clr_cnt;
    k_next       = k;
    l_next       = l;
    r_next       = r;
    acc_next     = acc;
    amt_next     = amt;
    lflag_next   = lflag;
    rflag_next   = rflag;
    we           = 1'b0;
    waddr        = k;
    wdata        = rdata + amt;
    raddr        = k;
    busy         = 1'b1;
    res.valid    = 1'b0;
    res.sum      = acc_r;

    case (state)
      pars_pkg::ST_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        wdata        = '0;
        clr_cnt_next = clr_cnt + pars_pkg::NODE_W'(1);
        if (clr_cnt == pars_pkg::NODE_W'(pars_pkg::NODE_SLOTS - 1)) begin
          state_next = pars_pkg::ST_IDLE;
        end
      end
      pars_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (go) begin
          if (cmd.opcode == pars_pkg::OP_ADD) begin
            // An add beyond the last leaf leaves the tree untouched.
            if (32'(cmd.first_index) < pars_pkg::LEAF_COUNT) begin
              k_next     = pars_pkg::NODE_W'(cmd.first_index)
                         + pars_pkg::NODE_W'(pars_pkg::LEAF_COUNT);
              raddr      = k_next;
              amt_next   = pars_pkg::DATA_WIDTH'(cmd.add_value);
              state_next = pars_pkg::ST_ADD_UPD;
            end
          end else begin
            l_next     = pars_pkg::CNT_W'(lo32) + pars_pkg::CNT_W'(pars_pkg::LEAF_COUNT);
            r_next     = pars_pkg::CNT_W'(hi32) + pars_pkg::CNT_W'(pars_pkg::LEAF_COUNT)
                       + pars_pkg::CNT_W'(1);
            acc_next   = '0;
            rflag_next = 1'b0;
            lflag_next = 1'b0;
            state_next = pars_pkg::ST_Q_LEFT;
          end
        end
      end
      pars_pkg::ST_ADD_UPD: begin
        // Write this node back while the parent is being read.
        we     = 1'b1;
        waddr  = k;
        wdata  = rdata + amt;
        raddr  = k >> 1;
        k_next = k >> 1;
        if (k == pars_pkg::NODE_W'(1)) begin
          state_next = pars_pkg::ST_IDLE;
        end
      end
      pars_pkg::ST_Q_LEFT: begin
        acc_next   = acc_r;
        rflag_next = 1'b0;
        if (l < r) begin
          raddr      = l[pars_pkg::NODE_W-1:0];
          lflag_next = l[0];
          state_next = pars_pkg::ST_Q_RIGHT;
        end else begin
          res.valid  = 1'b1;
          state_next = pars_pkg::ST_IDLE;
        end
      end
      pars_pkg::ST_Q_RIGHT: begin
        acc_next = acc + (lflag ? rdata : '0);
        l_next   = (l + pars_pkg::CNT_W'(l[0])) >> 1;
        raddr    = r_dec[pars_pkg::NODE_W-1:0];
        if (r[0]) begin
          rflag_next = 1'b1;
          r_next     = r_dec >> 1;
        end else begin
          rflag_next = 1'b0;
          r_next     = r >> 1;
        end
        state_next = pars_pkg::ST_Q_LEFT;
      end
      default: begin
        state_next = pars_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/point_add_range_sum_tree_top.sv
// Top level of the point-add range-sum tree: command port, result register, checks.
`default_nettype none
// Usage
//   A command beat is taken at a rising edge where start is high and busy is
//   low. opcode selects an add (add_value goes into leaf first_index and into
//   every ancestor up to the root) or a query (range_sum over the inclusive
//   leaf range between first_index and second_index, in either order, with
//   each bound saturated to the last leaf). All sums wrap at the data width.
//   An add gives no result beat; a query gives exactly one.
//   A result beat shows on range_sum for one cycle with done high. The
//   receiver cannot hold it off, and the next command may be taken in that
//   same cycle, so no result is ever lost.
//   Walk: an add spends one memory read-modify-write per tree level, and
//   done rises in the same cycle that busy falls. The node memory has one
//   read port with registered read data: an add overlaps each write-back
//   with the parent read, while a query needs two reads per level.
//   Reset: after rst the block runs a clearing pass that writes zero into
//   all 2*LEAF_COUNT node slots, one per cycle, with busy high.
module point_add_range_sum_tree_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              opcode,
  input  wire logic        [pars_pkg::IDX_W-1:0] first_index,
  input  wire logic        [pars_pkg::IDX_W-1:0] second_index,
  input  wire logic signed [pars_pkg::VAL_W-1:0] add_value,
  output logic                                   done,
  output logic signed      [pars_pkg::VAL_W-1:0] range_sum
);

  pars_pkg::cmd_t cmd;
  pars_pkg::res_t res;
  logic           go;

  assign cmd.opcode       = opcode;
  assign cmd.first_index  = first_index;
  assign cmd.second_index = second_index;
  assign cmd.add_value    = add_value;
  assign go               = start && !busy;

  pars_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .cmd  (cmd),
    .busy (busy),
    .res  (res)
  );

  // The result register frees the walker to take the next command at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      range_sum <= pars_pkg::VAL_W'($signed(res.sum));
    end
  end

  // An accepted add can never be followed directly by a result beat.
  a_add_no_result : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == pars_pkg::OP_ADD) |=> !done)
    else $error("result beat right after an accepted add");

  // A result beat only follows a cycle in which the walker was working.
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a preceding walk");

  // The clearing pass holds off commands as soon as reset is released.
  a_clear_busy : assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("busy low while the node memory is being cleared");

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the point-add range-sum tree: directed table, then random beats.
`timescale 1ns / 100ps
module testbench;
  import pars_pkg::*;

  // Number of random command beats after the directed table.
  localparam int RANDOM_BEATS = 1200;
  // The last beats go in back to back, with no gaps on the command side.
  localparam int CALM_TAIL    = 150;
  // Cycles without any accepted beat or result beat before the run is declared
  // hung. The clearing pass after reset is the longest such stretch.
  localparam int HANG_LIMIT   = 6000;
  localparam int DIRECTED_ROWS = 22;

  // One row of command stimulus. When check_sum is set on a query, sum_want
  // is the typed-in answer; otherwise the running leaf model supplies it.
  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [VAL_W-1:0] add_value;
    logic                    check_sum;
    logic signed [VAL_W-1:0] sum_want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic opcode = OP_ADD;
  logic [IDX_W-1:0] first_index = '0;
  logic [IDX_W-1:0] second_index = '0;
  logic signed [VAL_W-1:0] add_value = '0;
  logic busy;
  logic done;
  logic signed [VAL_W-1:0] range_sum;

  point_add_range_sum_tree_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .first_index  (first_index),
    .second_index (second_index),
    .add_value    (add_value),
    .done         (done),
    .range_sum    (range_sum)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps the leaves themselves rather than a tree. A range sum
  // is then a plain loop over the leaves, which gives the same value modulo
  // two to the data width as any tree walk, so it checks the walker
  // independently of how the hardware lays out its nodes.
  logic [DATA_WIDTH-1:0] leaf_totals [LEAF_COUNT];
  // Query answers still owed by the block, oldest first.
  logic signed [VAL_W-1:0] pending_sums [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  logic signed [VAL_W-1:0] oldest_sum;

  initial begin
    for (int i = 0; i < LEAF_COUNT; i++) leaf_totals[i] = '0;
  end

  // An add lands on one leaf. The amount is sign-extended from 32 bits and
  // then cut to the data width; a leaf beyond the last one is ignored.
  function automatic void apply_add(input logic [IDX_W-1:0] leaf,
                                    input logic signed [VAL_W-1:0] amount);
    if (leaf < LEAF_COUNT)
      leaf_totals[leaf] = leaf_totals[leaf] + DATA_WIDTH'(amount);
  endfunction

  // Inclusive range sum. Each bound saturates at the last leaf, and bounds
  // given in reverse order are swapped. The wrapped sum is sign-extended (or
  // cut) to the 32-bit result port.
  function automatic logic signed [VAL_W-1:0] range_total(input logic [IDX_W-1:0] a,
                                                         input logic [IDX_W-1:0] b);
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    logic signed [DATA_WIDTH-1:0] acc;
    lo = (a >= LEAF_COUNT) ? LEAF_COUNT - 1 : a;
    hi = (b >= LEAF_COUNT) ? LEAF_COUNT - 1 : b;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    acc = '0;
    for (int unsigned i = lo; i <= hi; i++) acc = acc + leaf_totals[i];
    return VAL_W'(acc);
  endfunction

  // Leaf choice for random beats: mostly anywhere, some near the two ends of
  // the leaf array, and a good share inside a small hot window so that
  // queries over that window see many overlapping adds.
  function automatic logic [IDX_W-1:0] pick_leaf(input int unsigned hot_base);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return IDX_W'($urandom_range(0, LEAF_COUNT - 1));
    if (roll == 5) return IDX_W'($urandom_range(0, 3));
    if (roll == 6) return IDX_W'($urandom_range(LEAF_COUNT - 4, LEAF_COUNT - 1));
    return IDX_W'(hot_base + $urandom_range(0, 63));
  endfunction

  function automatic stim_row_t random_row(input int unsigned hot_base);
    stim_row_t row;
    int unsigned roll;
    row = '0;
    row.opcode = $urandom_range(0, 1) ? OP_QUERY : OP_ADD;
    row.first_index = pick_leaf(hot_base);
    // For an add the second bound is don't-care, so it gets pure noise.
    row.second_index = IDX_W'($urandom_range(0, LEAF_COUNT - 1));
    row.add_value = VAL_W'($urandom());
    if (row.opcode == OP_ADD) begin
      roll = $urandom_range(0, 9);
      if (roll < 3) begin
        row.add_value = VAL_W'(int'($urandom_range(0, 200)) - 100);
      end else if (roll < 5) begin
        case ($urandom_range(0, 3))
          0: row.add_value = {1'b1, {(VAL_W - 1){1'b0}}};
          1: row.add_value = {1'b0, {(VAL_W - 1){1'b1}}};
          2: row.add_value = '1;
          default: row.add_value = '0;
        endcase
      end
    end else begin
      // Query shapes: random bounds in either order, a single leaf, a span
      // inside the hot window, or a range running out to one end.
      case ($urandom_range(0, 4))
        0, 1: ;
        2: row.second_index = row.first_index;
        3: row.second_index = IDX_W'(hot_base + $urandom_range(0, 63));
        default: row.second_index = $urandom_range(0, 1) ? '0 : '1;
      endcase
    end
    return row;
  endfunction

  // Present one command beat and hold it until the block takes it. An
  // optional burst of idle cycles goes first; it starts right after the
  // previous acceptance, so it can land anywhere in the block's work.
  task automatic issue_beat(input stim_row_t row, input bit allow_gap);
    int unsigned gap;
    gap = 0;
    if (allow_gap && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= row.opcode;
    first_index  <= row.first_index;
    second_index <= row.second_index;
    add_value    <= row.add_value;
    // busy is decoded from the registered state, so at the edge it still holds
    // the value the block had during the cycle that this edge closes.
    do @(posedge clk); while (busy);
    // Accepted: bring the predictor up to date.
    if (row.opcode == OP_ADD) begin
      apply_add(row.first_index, row.add_value);
    end else if (row.check_sum) begin
      pending_sums.push_back(row.sum_want);
    end else begin
      pending_sums.push_back(range_total(row.first_index, row.second_index));
    end
  endtask

  // Result side: a done beat must match the oldest owed sum. The same block
  // keeps the hang watchdog, which restarts on any accepted beat or result beat.
  always @(posedge clk) begin
    if (!rst && ((start && !busy) || done)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        $error("range_sum: unexpected result beat, actual %0d", range_sum);
        mismatch_count <= mismatch_count + 1;
      end else begin
        oldest_sum = pending_sums.pop_front();
        if (range_sum !== oldest_sum) begin
          $error("range_sum: expected %0d, actual %0d", oldest_sum, range_sum);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Directed table. Typed-in sums are those that follow at once from the
  // adds above them; the rest come from the leaf model.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Freshly cleared tree: the whole range, reversed, and a middle span.
    '{OP_QUERY, 10'd0,    10'd1023, 32'sd0,          1'b1, 32'sd0},
    '{OP_QUERY, 10'd1023, 10'd0,    32'sd0,          1'b1, 32'sd0},
    '{OP_QUERY, 10'd511,  10'd512,  32'sd0,          1'b1, 32'sd0},
    // Largest positive amount into the first leaf, one into the last leaf.
    '{OP_ADD,   10'd0,    10'd1023, 32'h7FFF_FFFF,   1'b0, 32'sd0},
    '{OP_ADD,   10'd1023, 10'd0,    32'sd1,          1'b0, 32'sd0},
    // The full range overflows and wraps to the most negative value.
    '{OP_QUERY, 10'd0,    10'd1023, 32'sd0,          1'b1, 32'h8000_0000},
    '{OP_QUERY, 10'd1023, 10'd1023, 32'sd0,          1'b1, 32'sd1},
    '{OP_QUERY, 10'd0,    10'd0,    32'sd0,          1'b1, 32'h7FFF_FFFF},
    // Most negative amount into the middle; the total wraps back to zero.
    '{OP_ADD,   10'd512,  10'd511,  32'h8000_0000,   1'b0, 32'sd0},
    '{OP_QUERY, 10'd1023, 10'd0,    32'sd0,          1'b1, 32'sd0},
    '{OP_QUERY, 10'd512,  10'd512,  32'sd0,          1'b1, 32'h8000_0000},
    // Minus one cancels the last leaf.
    '{OP_ADD,   10'd1023, 10'd1023, 32'hFFFF_FFFF,   1'b0, 32'sd0},
    '{OP_QUERY, 10'd1,    10'd1023, 32'sd0,          1'b1, 32'h8000_0000},
    // Alternating bit patterns on indexes and amounts.
    '{OP_ADD,   10'd341,  10'd682,  32'h5555_5555,   1'b0, 32'sd0},
    '{OP_ADD,   10'd682,  10'd341,  32'hAAAA_AAAA,   1'b0, 32'sd0},
    '{OP_QUERY, 10'd682,  10'd341,  32'sd0,          1'b0, 32'sd0},
    '{OP_QUERY, 10'd340,  10'd683,  32'sd0,          1'b0, 32'sd0},
    // Bring the first leaf back to zero by wrapping.
    '{OP_ADD,   10'd0,    10'd0,    32'h8000_0001,   1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd1,    32'sd0,          1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd1023, 32'sd0,          1'b0, 32'sd0},
    // Adding zero leaves an untouched leaf at zero.
    '{OP_ADD,   10'd700,  10'd1023, 32'sd0,          1'b0, 32'sd0},
    '{OP_QUERY, 10'd700,  10'd700,  32'sd0,          1'b1, 32'sd0}
  };

  initial begin
    int unsigned hot_base;
    bit gap_phase;
    hot_base = 0;
    gap_phase = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) issue_beat(directed_rows[i], 1'b1);

    // Random part. Gaps come and go in phases of 64 beats so that long
    // back-to-back stretches occur too, and stop for the final stretch.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) begin
        hot_base = $urandom_range(0, LEAF_COUNT - 64);
        gap_phase = $urandom_range(0, 2) != 0;
      end
      issue_beat(random_row(hot_base), gap_phase && (i < RANDOM_BEATS - CALM_TAIL));
    end
    start <= 1'b0;

    // Drain: every owed sum must arrive; then allow one more full walk for
    // anything still in flight.
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
